>>> design/sliding_window_max_min_spread_unit_defines.svh
// Assertion macros for the sliding window max/min spread unit.
// Depends on nothing; the asserting module supplies clock and reset signals.
`ifndef SLIDING_WINDOW_MAX_MIN_SPREAD_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAX_MIN_SPREAD_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SWMM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWMM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/swmm_pkg.sv
// Shared types and constants for the sliding window max/min spread unit.
// Depends on nothing; imported by the top level.
package swmm_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int AGE_W      = CNT_W;
   localparam int WIN_W      = 7;
   localparam int DATA_W     = 32;

   // deque select
   localparam logic DQ_MAX = 1'b0;
   localparam logic DQ_MIN = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     new_stream;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] window_max;
      logic signed [DATA_W-1:0] window_min;
      logic        [DATA_W-1:0] window_spread;
      logic        [DATA_W-1:0] best_spread;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic        [AGE_W-1:0]  age;
   } entry_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_START = 7'b0000010,
      ST_EXP   = 7'b0000100,
      ST_TAIL  = 7'b0001000,
      ST_PUSH  = 7'b0010000,
      ST_HEAD  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

>>> design/sliding_window_max_min_spread_unit.sv
// Sliding window maximum, minimum and spread over a signed sample stream.
// Depends on swmm_pkg and sliding_window_max_min_spread_unit_defines.svh.
//
// Usage:
//   req channel: one transaction carries a signed sample and a new_stream flag;
//     new_stream empties both deques, restarts the position count and clears
//     the running best spread before the sample is taken.
//   rsp channel: one transaction per request with window max, window min,
//     their spread and the largest spread since stream start.
//   csr port: write window_len (0 acts as 1, above 64 acts as 64) while idle.
// Sequence: for each deque the unit drops expired head entries, then tail
//   entries dominated by the new sample, then pushes the sample and reads the
//   head. The max deque is worked first, then the min deque, and the response
//   register is loaded at the end. The unit is idle right after the load, so a
//   new request is taken only once the previous one has loaded its response.
// Reset: synchronous; empties both deques, clears position and best spread,
//   sets window_len to 1 and drops any pending response.
// Stall: the response register holds while rsp_ready is low; the next request
//   is still accepted and processed, and waits only in its final step.
module sliding_window_max_min_spread_unit
   import swmm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data
);

`include "sliding_window_max_min_spread_unit_defines.svh"

   // deque memory: max deque in the lower half, min deque in the upper half
   entry_type mem [0:2*MAX_WINDOW-1];
   entry_type rd_q_ff;

   logic              rd_en;
   logic [ADDR_W:0]   rd_addr;
   logic              wr_en;
   logic [ADDR_W:0]   wr_addr;
   entry_type         wr_data;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   logic [ADDR_W-1:0] head_ff  [2];
   logic [ADDR_W-1:0] head_in  [2];
   logic [CNT_W-1:0]  count_ff [2];
   logic [CNT_W-1:0]  count_in [2];

   logic [AGE_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] best_ff, best_in;
   logic [WIN_W-1:0]  win_ff;
   req_type           sample_ff, sample_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // derived values for the deque under work
   logic [CNT_W-1:0]  win_eff;
   logic [ADDR_W-1:0] cur_head;
   logic [CNT_W-1:0]  cur_count;
   logic [ADDR_W-1:0] tail_slot;
   logic [ADDR_W-1:0] push_slot;
   logic [AGE_W-1:0]  age_diff;
   logic              expired;
   logic              dominated;
   logic [DATA_W-1:0] spread;
   logic [DATA_W-1:0] best_new;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (win_ff > WIN_W'(MAX_WINDOW)) begin
         win_eff = CNT_W'(MAX_WINDOW);
      end else begin
         win_eff = CNT_W'(win_ff);
      end
   end

   assign cur_head  = head_ff[sel_ff];
   assign cur_count = count_ff[sel_ff];
   assign tail_slot = cur_head + cur_count[ADDR_W-1:0] - ADDR_W'(1);
   assign push_slot = cur_head + cur_count[ADDR_W-1:0];
   // wrapping age difference; live entries are never more than a window old
   assign age_diff  = pos_ff - rd_q_ff.age;
   assign expired   = (CNT_W'(age_diff) >= win_eff);
   assign dominated = (sel_ff == DQ_MAX) ? (rd_q_ff.value <= sample_ff.sample)
                                         : (rd_q_ff.value >= sample_ff.sample);
   assign spread    = $unsigned(hi_ff - lo_ff);
   assign best_new  = (spread > best_ff) ? spread : best_ff;

   always_comb begin
      logic signed [DATA_W-1:0] head_val;
      logic                     deque_done;

      state_in     = state_ff;
      sel_in       = sel_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      sample_in    = sample_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      head_val     = rd_q_ff.value;
      deque_done   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_payload;
               sel_in    = DQ_MAX;
               state_in  = ST_START;
               if (req_payload.new_stream) begin
                  head_in[0]  = '0;
                  head_in[1]  = '0;
                  count_in[0] = '0;
                  count_in[1] = '0;
                  pos_in      = '0;
                  best_in     = '0;
               end
            end
         end
         ST_START: begin
            if (cur_count == '0) begin
               state_in = ST_PUSH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {sel_ff, cur_head};
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (expired) begin
               // drop the expired head
               head_in[sel_ff]  = cur_head + ADDR_W'(1);
               count_in[sel_ff] = cur_count - CNT_W'(1);
               if (cur_count == CNT_W'(1)) begin
                  state_in = ST_PUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = {sel_ff, cur_head + ADDR_W'(1)};
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {sel_ff, tail_slot};
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (dominated) begin
               // drop a tail entry that can never win again
               count_in[sel_ff] = cur_count - CNT_W'(1);
               if (cur_count == CNT_W'(1)) begin
                  state_in = ST_PUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = {sel_ff, tail_slot - ADDR_W'(1)};
               end
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            wr_en            = 1'b1;
            wr_addr          = {sel_ff, push_slot};
            wr_data.value    = sample_ff.sample;
            wr_data.age      = pos_ff;
            count_in[sel_ff] = cur_count + CNT_W'(1);
            if (cur_count == '0) begin
               head_val   = sample_ff.sample;
               deque_done = 1'b1;
            end else begin
               // head slot differs from the slot being written
               rd_en    = 1'b1;
               rd_addr  = {sel_ff, cur_head};
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            deque_done = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.window_max    = hi_ff;
               rsp_in.window_min    = lo_ff;
               rsp_in.window_spread = spread;
               rsp_in.best_spread   = best_new;
               rsp_valid_in         = 1'b1;
               best_in              = best_new;
               pos_in               = pos_ff + AGE_W'(1);
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capture the head value and move on to the min deque or finish
      if (deque_done) begin
         if (sel_ff == DQ_MAX) begin
            hi_in    = head_val;
            sel_in   = DQ_MIN;
            state_in = ST_START;
         end else begin
            lo_in    = head_val;
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= DQ_MAX;
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
         win_ff       <= WIN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      rsp_ff    <= rsp_in;
   end

   `SWMM_ASSERT_ALWAYS(a_reset_clears, reset |=> state_ff == ST_IDLE && !rsp_valid_ff, "reset did not clear control state")
   `SWMM_ASSERT(a_accept_leaves_idle, req_valid && req_ready |=> state_ff == ST_START, "accepted request did not start deque work")
   `SWMM_ASSERT(a_count_bound, count_ff[0] <= CNT_W'(MAX_WINDOW) && count_ff[1] <= CNT_W'(MAX_WINDOW), "deque fill exceeds capacity")
   `SWMM_ASSERT(a_done_nonempty, state_ff == ST_DONE |-> count_ff[0] != '0 && count_ff[1] != '0, "deque empty after push")
   `SWMM_ASSERT(a_max_ge_min, state_ff == ST_DONE |-> hi_ff >= lo_ff, "window maximum below window minimum")
   `SWMM_ASSERT(a_done_loads_rsp, state_ff == ST_DONE && state_in == ST_IDLE |=> rsp_valid_ff, "finished item did not load the response")

endmodule
